// ===== src/progressive_pixel_average_gamma_top_assert.svh =====
// Assertion macros for the progressive pixel average top level
`ifndef PROGRESSIVE_PIXEL_AVERAGE_GAMMA_TOP_ASSERT_SVH
`define PROGRESSIVE_PIXEL_AVERAGE_GAMMA_TOP_ASSERT_SVH

// check a consequence in the same cycle
`define PPAG_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// check a consequence in the next cycle
`define PPAG_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== src/ppag_pkg.sv =====
// Shared types, constants and helper functions for the pixel average block
`timescale 1ns / 1ps

package ppag_pkg;

    localparam int IDX_W               = 16;
    localparam int PASS_W              = 16;
    localparam int SAMPLE_W            = 24;
    localparam int GAMMA_W             = 16;
    localparam int DISP_W              = 8;
    localparam int CHANNELS            = 3;
    localparam int COLOR_FRACTION_BITS = 16;
    localparam int DIV_STAGES          = 12;
    localparam int LOG_STEPS           = 16;
    localparam int ROOT_STEPS          = 16;
    localparam int SHADE_DEPTH         = 36;

    localparam logic [GAMMA_W-1:0] INV_GAMMA_RESET = 16'd1862;

    localparam logic REG_INV_GAMMA = 1'b0;

    typedef struct packed {
        logic [PASS_W-1:0]   rem;
        logic [SAMPLE_W-1:0] work;
    } ppag_div_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] base;
        logic                neg;
        ppag_div_t           div;
    } ppag_chan_t;

    typedef struct packed {
        logic                               valid;
        logic [IDX_W-1:0]                   index;
        logic [CHANNELS-1:0][SAMPLE_W-1:0]  value;
    } ppag_avg_t;

    function automatic ppag_div_t ppag_div_step(input ppag_div_t cur,
                                                input logic [PASS_W-1:0] dvs);
        ppag_div_t     nxt;
        logic [PASS_W:0] t;
        t        = {cur.rem, cur.work[SAMPLE_W-1]};
        nxt.work = {cur.work[SAMPLE_W-2:0], 1'b0};
        if (t >= {1'b0, dvs})
        begin
            t           = t - {1'b0, dvs};
            nxt.work[0] = 1'b1;
        end
        nxt.rem = t[PASS_W-1:0];
        return nxt;
    endfunction

    // root k of two in Q1.30, each a floored square root of the one before
    function automatic logic [30:0] ppag_root(input int k);
        logic [63:0] cur;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        cur = 64'd2 << 30;
        for (int s = 1; s <= k; s++)
        begin
            v   = cur << 30;
            res = '0;
            bt  = 64'd1 << 62;
            for (int i = 0; i < 32; i++)
            begin
                if (v >= res + bt)
                begin
                    v   = v - (res + bt);
                    res = (res >> 1) + bt;
                end
                else
                begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
            cur = res;
        end
        return cur[30:0];
    endfunction

endpackage

// ===== src/ppag_if.sv =====
// Stream channel interfaces for samples in and display values out
`timescale 1ns / 1ps

interface ppag_sample_if import ppag_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    pixel_index;
    logic [PASS_W-1:0]   pass_number;
    logic [SAMPLE_W-1:0] sample_red;
    logic [SAMPLE_W-1:0] sample_green;
    logic [SAMPLE_W-1:0] sample_blue;

    modport source (
        output valid, pixel_index, pass_number, sample_red, sample_green, sample_blue,
        input  ready
    );
    modport sink (
        input  valid, pixel_index, pass_number, sample_red, sample_green, sample_blue,
        output ready
    );
endinterface

interface ppag_display_if import ppag_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  out_pixel_index;
    logic [DISP_W-1:0] display_red;
    logic [DISP_W-1:0] display_green;
    logic [DISP_W-1:0] display_blue;

    modport source (
        output valid, out_pixel_index, display_red, display_green, display_blue,
        input  ready
    );
    modport sink (
        input  valid, out_pixel_index, display_red, display_green, display_blue,
        output ready
    );
endinterface

// ===== src/ppag_avg.sv =====
// Running average store with pipelined divider and same-entry hazard hold
`timescale 1ns / 1ps

module ppag_avg
    import ppag_pkg::*;
#(
    parameter int PIXEL_COUNT = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    ppag_sample_if.sink sample_in,
    output ppag_avg_t   avg_out
);

    localparam int SLOT_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int MOD_W  = 40;
    localparam int WORD_W = CHANNELS * SAMPLE_W;

    logic [WORD_W-1:0] mem [PIXEL_COUNT];

    logic [SAMPLE_W-1:0] in_smp [CHANNELS];
    logic [IDX_W-1:0]    in_rem;
    logic                accept;

    logic                a_v_reg;
    logic [IDX_W-1:0]    a_idx_reg;
    logic [PASS_W-1:0]   a_pass_reg;
    logic [SAMPLE_W-1:0] a_smp_reg [CHANNELS];
    logic [IDX_W-1:0]    a_rem_reg;
    logic [IDX_W-1:0]    a_rem;
    logic [SLOT_W-1:0]   a_slot;
    logic                hit;
    logic                hazard;

    logic                s_v_reg;
    logic [IDX_W-1:0]    s_idx_reg;
    logic [PASS_W-1:0]   s_pass_reg;
    logic [SAMPLE_W-1:0] s_smp_reg [CHANNELS];
    logic [SLOT_W-1:0]   s_slot_reg;
    logic [WORD_W-1:0]   rd_reg;

    ppag_chan_t          p_ch [CHANNELS];
    logic [PASS_W-1:0]   p_dvs;

    logic [DIV_STAGES:0] d_v_reg;
    logic [IDX_W-1:0]    d_idx_reg  [DIV_STAGES+1];
    logic [SLOT_W-1:0]   d_slot_reg [DIV_STAGES+1];
    logic [PASS_W-1:0]   d_dvs_reg  [DIV_STAGES+1];
    ppag_chan_t          d_ch_reg   [DIV_STAGES+1][CHANNELS];

    logic [WORD_W-1:0]   new_word;

    logic                w_v_reg;
    logic [IDX_W-1:0]    w_idx_reg;
    logic [WORD_W-1:0]   w_val_reg;

    assign in_smp[0] = sample_in.sample_red;
    assign in_smp[1] = sample_in.sample_green;
    assign in_smp[2] = sample_in.sample_blue;

    always_comb
    begin
        in_rem = sample_in.pixel_index;
        for (int k = IDX_W - 1; k >= IDX_W / 2; k--)
        begin
            if ({24'd0, in_rem} >= (MOD_W'(PIXEL_COUNT) << k))
            begin
                in_rem = in_rem - IDX_W'(MOD_W'(PIXEL_COUNT) << k);
            end
        end
    end

    always_comb
    begin
        a_rem = a_rem_reg;
        for (int k = IDX_W / 2 - 1; k >= 0; k--)
        begin
            if ({24'd0, a_rem} >= (MOD_W'(PIXEL_COUNT) << k))
            begin
                a_rem = a_rem - IDX_W'(MOD_W'(PIXEL_COUNT) << k);
            end
        end
        a_slot = SLOT_W'(a_rem);
    end

    always_comb
    begin
        hit = s_v_reg && (s_slot_reg == a_slot);
        for (int k = 0; k <= DIV_STAGES; k++)
        begin
            hit = hit || (d_v_reg[k] && (d_slot_reg[k] == a_slot));
        end
        hazard = a_v_reg && (a_pass_reg > PASS_W'(1)) && hit;
    end

    assign sample_in.ready = adv && (!a_v_reg || !hazard);
    assign accept          = sample_in.valid && sample_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            s_v_reg <= 1'b0;
            d_v_reg <= '0;
            w_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= accept || (a_v_reg && hazard);
            s_v_reg <= a_v_reg && !hazard;
            d_v_reg <= {d_v_reg[DIV_STAGES-1:0], s_v_reg};
            w_v_reg <= d_v_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_idx_reg  <= sample_in.pixel_index;
            a_pass_reg <= sample_in.pass_number;
            a_rem_reg  <= in_rem;
            for (int c = 0; c < CHANNELS; c++)
            begin
                a_smp_reg[c] <= in_smp[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_idx_reg  <= a_idx_reg;
            s_pass_reg <= a_pass_reg;
            s_slot_reg <= a_slot;
            for (int c = 0; c < CHANNELS; c++)
            begin
                s_smp_reg[c] <= a_smp_reg[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_reg <= mem[a_slot];
            if (d_v_reg[DIV_STAGES])
            begin
                mem[d_slot_reg[DIV_STAGES]] <= new_word;
            end
        end
    end

    always_comb
    begin
        logic                ow;
        logic [SAMPLE_W-1:0] old;
        ow    = s_pass_reg <= PASS_W'(1);
        p_dvs = ow ? PASS_W'(1) : s_pass_reg;
        for (int c = 0; c < CHANNELS; c++)
        begin
            old                = rd_reg[c*SAMPLE_W +: SAMPLE_W];
            p_ch[c].div.rem    = '0;
            if (ow)
            begin
                p_ch[c].base     = '0;
                p_ch[c].neg      = 1'b0;
                p_ch[c].div.work = s_smp_reg[c];
            end
            else if (s_smp_reg[c] >= old)
            begin
                p_ch[c].base     = old;
                p_ch[c].neg      = 1'b0;
                p_ch[c].div.work = s_smp_reg[c] - old;
            end
            else
            begin
                p_ch[c].base     = old;
                p_ch[c].neg      = 1'b1;
                p_ch[c].div.work = old - s_smp_reg[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_idx_reg[0]  <= s_idx_reg;
            d_slot_reg[0] <= s_slot_reg;
            d_dvs_reg[0]  <= p_dvs;
            for (int c = 0; c < CHANNELS; c++)
            begin
                d_ch_reg[0][c] <= p_ch[c];
            end
        end
    end

    for (genvar k = 1; k <= DIV_STAGES; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_idx_reg[k]  <= d_idx_reg[k-1];
                d_slot_reg[k] <= d_slot_reg[k-1];
                d_dvs_reg[k]  <= d_dvs_reg[k-1];
                for (int c = 0; c < CHANNELS; c++)
                begin
                    d_ch_reg[k][c].base <= d_ch_reg[k-1][c].base;
                    d_ch_reg[k][c].neg  <= d_ch_reg[k-1][c].neg;
                    d_ch_reg[k][c].div  <= ppag_div_step(
                        ppag_div_step(d_ch_reg[k-1][c].div, d_dvs_reg[k-1]),
                        d_dvs_reg[k-1]);
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (d_ch_reg[DIV_STAGES][c].neg)
            begin
                new_word[c*SAMPLE_W +: SAMPLE_W] =
                    d_ch_reg[DIV_STAGES][c].base - d_ch_reg[DIV_STAGES][c].div.work;
            end
            else
            begin
                new_word[c*SAMPLE_W +: SAMPLE_W] =
                    d_ch_reg[DIV_STAGES][c].base + d_ch_reg[DIV_STAGES][c].div.work;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_idx_reg <= d_idx_reg[DIV_STAGES];
            w_val_reg <= new_word;
        end
    end

    assign avg_out.valid = w_v_reg;
    assign avg_out.index = w_idx_reg;
    assign avg_out.value = w_val_reg;

endmodule

// ===== src/ppag_shade.sv =====
// Clamp, log2, gamma scale, exp2 and 8-bit rounding pipeline for one channel
`timescale 1ns / 1ps

module ppag_shade
    import ppag_pkg::*;
(
    input  logic                clk,
    input  logic                adv,
    input  logic [GAMMA_W-1:0]  inverse_gamma,
    input  logic [SAMPLE_W-1:0] avg_in,
    output logic [DISP_W-1:0]   disp
);

    logic [4:0]  n_p;
    logic [54:0] n_wide;
    logic        n_hi;
    logic        n_lo;

    logic [30:0] m_reg  [LOG_STEPS+1];
    logic [15:0] fr_reg [LOG_STEPS+1];
    logic [4:0]  ip_reg [LOG_STEPS+1];
    logic        lh_reg [LOG_STEPS+1];
    logic        ll_reg [LOG_STEPS+1];

    logic [20:0] e_neg;
    logic [36:0] e_prod;
    logic [36:0] e_sum;
    logic [24:0] e_val;
    logic [16:0] e_h;

    logic [30:0] r_reg  [ROOT_STEPS+1];
    logic [15:0] h_reg  [ROOT_STEPS+1];
    logic [3:0]  n_reg  [ROOT_STEPS+1];
    logic        fz_reg [ROOT_STEPS+1];
    logic        xh_reg [ROOT_STEPS+1];
    logic        xl_reg [ROOT_STEPS+1];

    logic [4:0]  y_sh;
    logic [30:0] y_reg;
    logic        yh_reg;
    logic        yl_reg;

    logic [38:0] f_scaled;
    logic [38:0] f_sum;
    logic [8:0]  f_v;
    logic [DISP_W-1:0] disp_reg;

    always_comb
    begin
        n_p = '0;
        for (int i = 0; i < SAMPLE_W; i++)
        begin
            if (avg_in[i])
            begin
                n_p = 5'(i);
            end
        end
        n_wide = {31'd0, avg_in} << (5'd30 - n_p);
        n_hi   = (inverse_gamma == '0) ||
                 ({1'b0, avg_in} >= (25'd1 << COLOR_FRACTION_BITS));
        n_lo   = avg_in == '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg[0]  <= n_wide[30:0];
            fr_reg[0] <= '0;
            ip_reg[0] <= 5'(COLOR_FRACTION_BITS) - n_p;
            lh_reg[0] <= n_hi;
            ll_reg[0] <= n_lo;
        end
    end

    for (genvar k = 1; k <= LOG_STEPS; k++)
    begin : g_log
        logic [61:0] sq;
        assign sq = m_reg[k-1] * m_reg[k-1];
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                m_reg[k]  <= sq[61] ? sq[61:31] : sq[60:30];
                fr_reg[k] <= {fr_reg[k-1][14:0], sq[61]};
                ip_reg[k] <= ip_reg[k-1];
                lh_reg[k] <= lh_reg[k-1];
                ll_reg[k] <= ll_reg[k-1];
            end
        end
    end

    always_comb
    begin
        e_neg  = {ip_reg[LOG_STEPS], 16'd0} - {5'd0, fr_reg[LOG_STEPS]};
        e_prod = e_neg * inverse_gamma;
        e_sum  = e_prod + 37'd2048;
        e_val  = e_sum[36:12];
        e_h    = 17'h10000 - {1'b0, e_val[15:0]};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg[0]  <= 31'h40000000;
            h_reg[0]  <= e_h[15:0];
            n_reg[0]  <= e_val[19:16];
            fz_reg[0] <= e_val[15:0] == '0;
            xh_reg[0] <= lh_reg[LOG_STEPS];
            xl_reg[0] <= ll_reg[LOG_STEPS] || (e_val[24:16] >= 9'd9);
        end
    end

    for (genvar k = 1; k <= ROOT_STEPS; k++)
    begin : g_exp
        localparam logic [30:0] ROOT_K = ppag_root(k);
        logic [61:0] prod;
        assign prod = r_reg[k-1] * ROOT_K;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r_reg[k]  <= h_reg[k-1][ROOT_STEPS-k] ? prod[60:30] : r_reg[k-1];
                h_reg[k]  <= h_reg[k-1];
                n_reg[k]  <= n_reg[k-1];
                fz_reg[k] <= fz_reg[k-1];
                xh_reg[k] <= xh_reg[k-1];
                xl_reg[k] <= xl_reg[k-1];
            end
        end
    end

    assign y_sh = {1'b0, n_reg[ROOT_STEPS]} + 5'd1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y_reg  <= fz_reg[ROOT_STEPS] ? (31'h40000000 >> n_reg[ROOT_STEPS])
                                         : (r_reg[ROOT_STEPS] >> y_sh);
            yh_reg <= xh_reg[ROOT_STEPS];
            yl_reg <= xl_reg[ROOT_STEPS];
        end
    end

    always_comb
    begin
        f_scaled = {y_reg, 8'd0} - {8'd0, y_reg};
        f_sum    = f_scaled + 39'h20000000;
        f_v      = f_sum[38:30];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (yh_reg)
            begin
                disp_reg <= 8'hFF;
            end
            else if (yl_reg)
            begin
                disp_reg <= 8'h00;
            end
            else if (f_v[8])
            begin
                disp_reg <= 8'hFF;
            end
            else
            begin
                disp_reg <= f_v[7:0];
            end
        end
    end

    assign disp = disp_reg;

endmodule

// ===== src/progressive_pixel_average_gamma_top.sv =====
// Top level: config register, average store, shade pipelines and output skid
//
//   channel      dir  handshake        beat contents
//   sample_in    in   valid/ready      pixel index, pass number, RGB samples
//   display_out  out  valid/ready      pixel index, RGB display bytes
//   apb          in   psel/penable     inverse gamma register at byte 0
//
// One beat per cycle sustained while no hazard wait or output stall holds the input.
// A beat with pass above one waits while an earlier beat for the same store
// entry is in the 14 stages between store read and write-back.
// Reset clears valid bits and loads inverse gamma; the store is not cleared.
// An output stall holds the whole pipeline once the skid register fills.
`timescale 1ns / 1ps

`include "progressive_pixel_average_gamma_top_assert.svh"

module progressive_pixel_average_gamma_top
    import ppag_pkg::*;
#(
    parameter int PIXEL_COUNT = 65536
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    ppag_sample_if.sink   sample_in,
    ppag_display_if.source display_out
);

    logic [GAMMA_W-1:0] gamma_reg;
    logic               adv;
    ppag_avg_t          avg_out;

    logic [SHADE_DEPTH-1:0] lv_reg;
    logic [IDX_W-1:0]       li_reg [SHADE_DEPTH];
    logic [DISP_W-1:0]      disp [CHANNELS];

    logic               push;
    logic               pop;
    logic               out_v_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic [DISP_W-1:0]  out_disp_reg [CHANNELS];
    logic               skid_v_reg;
    logic [IDX_W-1:0]   skid_idx_reg;
    logic [DISP_W-1:0]  skid_disp_reg [CHANNELS];

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_INV_GAMMA) ? {16'd0, gamma_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= INV_GAMMA_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_INV_GAMMA))
        begin
            gamma_reg <= pwdata[GAMMA_W-1:0];
        end
    end

    assign adv = !skid_v_reg;

    ppag_avg #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_avg (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .sample_in (sample_in),
        .avg_out   (avg_out)
    );

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_shade
        ppag_shade u_shade (
            .clk           (clk),
            .adv           (adv),
            .inverse_gamma (gamma_reg),
            .avg_in        (avg_out.value[c]),
            .disp          (disp[c])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lv_reg <= '0;
        end
        else if (adv)
        begin
            lv_reg <= {lv_reg[SHADE_DEPTH-2:0], avg_out.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            li_reg[0] <= avg_out.index;
            for (int k = 1; k < SHADE_DEPTH; k++)
            begin
                li_reg[k] <= li_reg[k-1];
            end
        end
    end

    assign push = adv && lv_reg[SHADE_DEPTH-1];
    assign pop  = out_v_reg && display_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (pop)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            out_v_reg <= 1'b1;
            if (out_v_reg && !pop)
            begin
                skid_v_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (pop)
            begin
                out_idx_reg  <= skid_idx_reg;
                out_disp_reg <= skid_disp_reg;
            end
        end
        else if (push)
        begin
            if (!out_v_reg || pop)
            begin
                out_idx_reg  <= li_reg[SHADE_DEPTH-1];
                out_disp_reg <= disp;
            end
            else
            begin
                skid_idx_reg  <= li_reg[SHADE_DEPTH-1];
                skid_disp_reg <= disp;
            end
        end
    end

    assign display_out.valid           = out_v_reg;
    assign display_out.out_pixel_index = out_idx_reg;
    assign display_out.display_red     = out_disp_reg[0];
    assign display_out.display_green   = out_disp_reg[1];
    assign display_out.display_blue    = out_disp_reg[2];

    `PPAG_ASSERT_NOW(a_skid_needs_out, skid_v_reg, out_v_reg, "skid holds a beat while output is empty")
    `PPAG_ASSERT_NOW(a_skid_blocks_in, skid_v_reg, !sample_in.ready, "input taken while skid is full")
    `PPAG_ASSERT_NOW(a_skid_cause, $rose(skid_v_reg), $past(out_v_reg && !display_out.ready), "skid filled without an output stall")
    `PPAG_ASSERT_NEXT(a_pop_drains, skid_v_reg && pop, !skid_v_reg && out_v_reg, "skid not moved to output on pop")

endmodule
